FILE: hw/rtl/mtf_pkg.sv
// Shared types and constants for the move-to-front LRU cache.
// No dependencies; mtf_cell and move_to_front_lru_cache use this package, mtf_chan_if does not.
package mtf_pkg;

	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int ENTRIES_DEF = 8;

	// One request transfer
	typedef struct packed {
		logic [KEY_W-1:0] lookup_key;
		logic [VAL_W-1:0] fill_value;
		logic             fill_ok;
	} req_t;

	// One response transfer
	typedef struct packed {
		logic             hit;
		logic             status;
		logic [VAL_W-1:0] value_out;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
		logic [VAL_W-1:0] evicted_value;
	} rsp_t;

	// Content of one list slot, handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;  // capture the tag compare
		logic upd_en;  // apply the list update
		logic insert;  // update is a miss fill, not a hit
	} cell_ctl_t;

endpackage

FILE: hw/rtl/mtf_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
// Payload type is a parameter; uses no package.
interface mtf_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/mtf_cell.sv
// One slot of the recency list: holds an entry, compares the request tag,
// and shifts in its front neighbor's entry. Depends on mtf_pkg.
module mtf_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mtf_pkg::cell_ctl_t        ctl,
	input  logic [mtf_pkg::KEY_W-1:0] key,
	input  mtf_pkg::entry_t           prev,
	input  logic                      seen_in,
	input  logic [mtf_pkg::VAL_W-1:0] sel_in,
	output mtf_pkg::entry_t           ent,
	output logic                      seen_out,
	output logic [mtf_pkg::VAL_W-1:0] sel_out
);
	logic                      valid_q;
	logic [mtf_pkg::KEY_W-1:0] key_q;
	logic [mtf_pkg::VAL_W-1:0] value_q;
	logic                      match_q;
	logic                      shift;

	// Match at this slot or any slot behind it
	assign seen_out = match_q | seen_in;
	assign sel_out  = (match_q ? value_q : '0) | sel_in;
	assign shift    = ctl.upd_en & (ctl.insert | seen_out);

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				match_q <= valid_q & (key_q == key);
			end
			if (shift) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end
endmodule

FILE: hw/rtl/move_to_front_lru_cache.sv
// Move-to-front LRU cache: a row of ENTRIES cells ordered from most to least recent.
// Response path: request register, compare in ST_CMP, then update in ST_UPD into the output register.
// A new request is taken only in idle, once the compare/update sequence of the last one is done.
// The request side stays ready while a finished response waits in the output register.
// Reset: asynchronous, active low; clears all slot valid bits and the sequencer, no sweep.
// Depends on mtf_pkg, mtf_chan_if and mtf_cell.
module move_to_front_lru_cache #(
	parameter int ENTRIES = mtf_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mtf_chan_if.sink   req,
	mtf_chan_if.source rsp
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t        state_q;
	mtf_pkg::req_t req_q;
	mtf_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	mtf_pkg::cell_ctl_t        ctl;
	mtf_pkg::entry_t           front;
	mtf_pkg::entry_t           ent   [ENTRIES];
	mtf_pkg::entry_t           prev  [ENTRIES];
	logic [ENTRIES:0]          seen;
	logic [mtf_pkg::VAL_W-1:0] sel   [ENTRIES+1];

	logic req_fire;
	logic upd_fire;
	logic hit;
	logic ins;
	logic [mtf_pkg::VAL_W-1:0] hit_value;
	mtf_pkg::entry_t           tail;

	// Take a request only between items; the output register decouples the sink.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid & req.ready;

	// Update only when the output register is free or drains in this cycle.
	assign upd_fire = (state_q == ST_UPD) & (~rsp_valid_q | rsp.ready);

	assign hit       = seen[0];
	assign hit_value = sel[0];
	assign ins       = ~hit & req_q.fill_ok;
	assign tail      = ent[ENTRIES-1];

	assign ctl.cmp_en = (state_q == ST_CMP);
	assign ctl.upd_en = upd_fire & (hit | req_q.fill_ok);
	assign ctl.insert = ~hit;

	// New front entry: the hit entry moving up, or the freshly filled one
	assign front.valid = 1'b1;
	assign front.key   = req_q.lookup_key;
	assign front.value = hit ? hit_value : req_q.fill_value;

	// Tail end of the match and value chains
	assign seen[ENTRIES] = 1'b0;
	assign sel[ENTRIES]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev[i] = front;
		end else begin : g_body
			assign prev[i] = ent[i-1];
		end

		mtf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key      (req_q.lookup_key),
			.prev     (prev[i]),
			.seen_in  (seen[i+1]),
			.sel_in   (sel[i+1]),
			.ent      (ent[i]),
			.seen_out (seen[i]),
			.sel_out  (sel[i])
		);
	end

	// Sequencer: idle -> compare -> update, holding in update while the output is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req_fire) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD:  if (upd_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the request and the finished response
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req.payload;
		end
		if (upd_fire) begin
			rsp_q.hit           <= hit;
			rsp_q.status        <= ~hit & ~req_q.fill_ok;
			rsp_q.value_out     <= hit ? hit_value : (req_q.fill_ok ? req_q.fill_value : '0);
			rsp_q.evicted       <= ins & tail.valid;
			rsp_q.evicted_key   <= (ins & tail.valid) ? tail.key : '0;
			rsp_q.evicted_value <= (ins & tail.valid) ? tail.value : '0;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;
endmodule

FILE: sim/move_to_front_lru_cache_tb.sv
// Self-checking testbench for move_to_front_lru_cache: directed and random lookups with a
// recency-list predictor, random idling on both channels and an in-order response check.
// Depends on mtf_pkg, mtf_chan_if and the move_to_front_lru_cache RTL.
`timescale 1ns / 1ps

module move_to_front_lru_cache_tb;

	localparam int CACHE_ENTRIES = mtf_pkg::ENTRIES_DEF;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;   // margin over the request-to-response latency
	localparam int KEY_POOL_SIZE = 12;  // more keys than slots, so hits and evictions both occur
	localparam int PRINT_LIMIT   = 50;

	logic clk;
	logic arst_n;

	mtf_chan_if #(.payload_t(mtf_pkg::req_t)) req_ch ();
	mtf_chan_if #(.payload_t(mtf_pkg::rsp_t)) rsp_ch ();

	move_to_front_lru_cache #(
		.ENTRIES(CACHE_ENTRIES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Predicted recency list: slot 0 is the most recently used entry.
	mtf_pkg::entry_t lru_list [CACHE_ENTRIES];
	// Predicted responses, oldest first, one per accepted request transfer.
	mtf_pkg::rsp_t   pending_rsps [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;   // chance in percent that the request side holds off a cycle
	int ready_idle_pct = 0;   // chance in percent that the response side drops ready

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Count cycles and end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Toggle response-side ready at random; a zero idle share holds it high.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
	end

	// Apply one lookup to the predicted list and return the response it must produce.
	function automatic mtf_pkg::rsp_t predict_lookup(input mtf_pkg::req_t item);
		mtf_pkg::rsp_t   res;
		mtf_pkg::entry_t moved;
		int              slot;

		res  = '0;
		slot = -1;
		// Parallel tag compare over valid slots; the lowest match wins.
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (slot < 0 && lru_list[i].valid && lru_list[i].key == item.lookup_key) begin
				slot = i;
			end
		end

		if (slot >= 0) begin
			// Hit: move the entry to the front, fill fields play no part.
			moved = lru_list[slot];
			for (int i = slot; i > 0; i--) begin
				lru_list[i] = lru_list[i - 1];
			end
			lru_list[0]   = moved;
			res.hit       = 1'b1;
			res.value_out = moved.value;
		end else if (item.fill_ok) begin
			// Miss with a good fill: report the last slot if the list is full, then shift.
			if (lru_list[CACHE_ENTRIES - 1].valid) begin
				res.evicted       = 1'b1;
				res.evicted_key   = lru_list[CACHE_ENTRIES - 1].key;
				res.evicted_value = lru_list[CACHE_ENTRIES - 1].value;
			end
			for (int i = CACHE_ENTRIES - 1; i > 0; i--) begin
				lru_list[i] = lru_list[i - 1];
			end
			lru_list[0].valid = 1'b1;
			lru_list[0].key   = item.lookup_key;
			lru_list[0].value = item.fill_value;
			res.value_out     = item.fill_value;
		end else begin
			// Miss with a failed fill: list untouched, all data fields zero.
			res.status = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		end
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// Check every response transfer against the oldest prediction.
	always @(posedge clk) begin : check_rsp
		mtf_pkg::rsp_t want;
		mtf_pkg::rsp_t got;

		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (pending_rsps.size() == 0) begin
				report_mismatch("response with no request outstanding", got.value_out, '0);
			end else begin
				want = pending_rsps.pop_front();
				compare_field("hit", 32'(got.hit), 32'(want.hit));
				compare_field("status", 32'(got.status), 32'(want.status));
				compare_field("value_out", got.value_out, want.value_out);
				compare_field("evicted", 32'(got.evicted), 32'(want.evicted));
				compare_field("evicted_key", got.evicted_key, want.evicted_key);
				compare_field("evicted_value", got.evicted_value, want.evicted_value);
			end
		end
	end

	// Drive one request, hold it until the transfer, then record its prediction.
	task automatic send_request(input logic [mtf_pkg::KEY_W-1:0] key,
			input logic [mtf_pkg::VAL_W-1:0] value, input logic ok);
		mtf_pkg::req_t item;

		item.lookup_key = key;
		item.fill_value = value;
		item.fill_ok    = ok;
		// Insert a random gap before this request.
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= item;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_rsps.push_back(predict_lookup(item));
	endtask

	// Drop valid and hold off until every predicted response has come back.
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_rsps.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Failed fills on an empty list: status set, nothing inserted.
	task automatic test_failed_fill_on_empty();
		send_request(32'h0000_0000, 32'hDEAD_BEEF, 1'b0);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
	endtask

	// Fill every slot with no eviction; extreme keys and values go in first.
	task automatic test_fill_to_capacity();
		send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		send_request(32'h0000_0001, $urandom, 1'b1);
		send_request(32'h0000_0002, $urandom, 1'b1);
		send_request(32'h0000_0010, $urandom, 1'b1);
		send_request(32'h0000_0100, $urandom, 1'b1);
		send_request(32'h0001_0000, $urandom, 1'b1);
		send_request(32'h1234_5678, $urandom, 1'b1);
	endtask

	// Hits from the back, the front and the middle; fill fields must be ignored.
	task automatic test_hits_reorder();
		send_request(32'h0000_0000, $urandom, 1'b0);   // least recent, failed fill flag
		send_request(32'h0000_0000, $urandom, 1'b1);   // now at the front
		send_request(32'h0000_0010, $urandom, 1'b1);   // middle of the list
	endtask

	// Misses on a full list evict the least recent entry; a failed fill evicts nothing.
	task automatic test_evictions();
		send_request(32'hA5A5_5A5A, $urandom, 1'b1);
		send_request(32'h8000_0000, $urandom, 1'b1);
		send_request(32'h7FFF_FFFF, $urandom, 1'b0);
		send_request(32'hFFFF_FFFF, $urandom, 1'b1);   // refill an evicted key
	endtask

	// Mostly keys from a small pool so the list sees hits, refills and evictions;
	// the rest are fresh random keys. Pause for a full drain halfway through.
	task automatic test_random_traffic(input int count);
		logic [mtf_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
		logic [mtf_pkg::KEY_W-1:0] key;

		for (int i = 0; i < KEY_POOL_SIZE; i++) begin
			key_pool[i] = $urandom;
		end
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				wait_for_drain();
			end
			// Churn the pool now and then so old keys age out for good.
			if ($urandom_range(99) < 3) begin
				key_pool[$urandom_range(KEY_POOL_SIZE - 1)] = $urandom;
			end
			if ($urandom_range(99) < 85) begin
				key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
			end else begin
				key = $urandom;
			end
			send_request(key, $urandom, $urandom_range(99) < 85);
		end
		wait_for_drain();
	endtask

	initial begin
		// Hold the request side at a known value through reset.
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			lru_list[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slow receiver, mildly bursty sender.
		send_idle_pct  = 26;
		ready_idle_pct = 73;
		test_failed_fill_on_empty();
		test_fill_to_capacity();
		test_hits_reorder();
		test_evictions();
		wait_for_drain();
		test_random_traffic(290);

		// Slow sender, mostly ready receiver.
		send_idle_pct  = 73;
		ready_idle_pct = 26;
		test_random_traffic(290);

		// Back to back on both sides.
		send_idle_pct  = 0;
		ready_idle_pct = 0;
		test_random_traffic(300);

		if (mismatch_count == 0 && pending_rsps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
